FILE: hw/rtl/plasma_texel_generator_defines.svh
// Assertion macros shared by the plasma texel generator RTL.
`ifndef PLASMA_TEXEL_GENERATOR_DEFINES_SVH
`define PLASMA_TEXEL_GENERATOR_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PTG_ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: invariant violated");

// A condition that must be followed by a consequence in the next cycle.
`define PTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check violated");

`endif

FILE: hw/rtl/ptg_pkg.sv
// Types, constants and trigonometric tables for the plasma texel generator.
`default_nettype none

package ptg_pkg;

  localparam int ANGLE_W      = 9;
  localparam int TRIG_W       = 10;
  localparam int AMP_W        = 11;
  localparam int PROD_W       = 21;
  localparam int LOW_W        = 8;
  localparam int PIXEL_W      = 16;
  localparam int TEXEL_OFFSET = 30;
  localparam int AMP_RESET    = 256;
  localparam int QUARTER_N    = 65;

  localparam logic signed [TRIG_W-1:0] QUARTER_WAVE [0:QUARTER_N-1] = '{
    10'sd0,   10'sd6,   10'sd12,  10'sd18,  10'sd25,  10'sd31,  10'sd37,  10'sd43,
    10'sd49,  10'sd56,  10'sd62,  10'sd68,  10'sd74,  10'sd80,  10'sd86,  10'sd92,
    10'sd97,  10'sd103, 10'sd109, 10'sd115, 10'sd120, 10'sd126, 10'sd131, 10'sd136,
    10'sd142, 10'sd147, 10'sd152, 10'sd157, 10'sd162, 10'sd167, 10'sd171, 10'sd176,
    10'sd181, 10'sd185, 10'sd189, 10'sd193, 10'sd197, 10'sd201, 10'sd205, 10'sd209,
    10'sd212, 10'sd216, 10'sd219, 10'sd222, 10'sd225, 10'sd228, 10'sd231, 10'sd234,
    10'sd236, 10'sd238, 10'sd241, 10'sd243, 10'sd244, 10'sd246, 10'sd248, 10'sd249,
    10'sd251, 10'sd252, 10'sd253, 10'sd254, 10'sd254, 10'sd255, 10'sd255, 10'sd255,
    10'sd256
  };

  typedef struct packed {
    logic in_valid;
    logic load_s1;
    logic load_s2;
  } ptg_frame_ctl_t;

  typedef struct packed {
    logic load_s3;
    logic load_s4;
  } ptg_disp_ctl_t;

  typedef struct packed {
    logic valid_a;
    logic valid_b;
  } ptg_stage_sts_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] amp_x;
    logic signed [AMP_W-1:0] amp_y;
    logic [ANGLE_W-1:0]      idx_sin;
    logic [ANGLE_W-1:0]      idx_cos;
    logic [LOW_W-1:0]        x_low;
    logic [LOW_W-1:0]        y_low;
  } ptg_disp_req_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic [LOW_W-1:0]         x_low;
    logic [LOW_W-1:0]         y_low;
  } ptg_shade_req_t;

  // Q8 sine of m*pi/128, built from the quarter wave.
  function automatic logic signed [TRIG_W-1:0] wave_at(input logic [ANGLE_W-1:0] m);
    logic [7:0] m8;
    logic [6:0] idx;
    logic       neg;
    m8 = m[7:0];
    priority if (m8 <= 8'd64) begin
      idx = m8[6:0];
      neg = 1'b0;
    end else if (m8 <= 8'd128) begin
      idx = 7'(8'd128 - m8);
      neg = 1'b0;
    end else if (m8 <= 8'd192) begin
      idx = 7'(m8 - 8'd128);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd256 - {1'b0, m8});
      neg = 1'b1;
    end
    return neg ? -QUARTER_WAVE[idx] : QUARTER_WAVE[idx];
  endfunction

  function automatic logic signed [TRIG_W-1:0] sine_at(input logic [ANGLE_W-1:0] m);
    return wave_at(m);
  endfunction

  function automatic logic signed [TRIG_W-1:0] cosine_at(input logic [ANGLE_W-1:0] m);
    return wave_at(m + 9'd64);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ptg_frame.sv
// Frame angle state, amplitude registers and displacement index stage.
`default_nettype none
`include "plasma_texel_generator_defines.svh"

module ptg_frame
  import ptg_pkg::*;
#(
  parameter int COORD_W = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ptg_frame_ctl_t       ctl,
  input  wire logic                 first_of_frame,
  input  wire logic [COORD_W-1:0]   tex_x,
  input  wire logic [COORD_W-1:0]   tex_y,
  output ptg_stage_sts_t            sts,
  output ptg_disp_req_t             req,
  output logic [2*COORD_W-1:0]      address
);

  localparam int XW = (COORD_W >= ANGLE_W) ? COORD_W + 1 : ANGLE_W + 1;

  logic                    accept;
  logic [ANGLE_W-1:0]      x_angle;
  logic [ANGLE_W-1:0]      y_angle;
  logic [ANGLE_W-1:0]      x_angle_next;
  logic [ANGLE_W-1:0]      y_angle_next;
  logic signed [AMP_W-1:0] x_amplitude;
  logic signed [AMP_W-1:0] y_amplitude;
  logic signed [AMP_W-1:0] amp_x_new;
  logic signed [AMP_W-1:0] amp_y_new;

  logic                    s1_valid;
  logic                    s1_first;
  logic [COORD_W-1:0]      s1_tex_x;
  logic [COORD_W-1:0]      s1_tex_y;
  logic [ANGLE_W-1:0]      s1_x_angle;
  logic [ANGLE_W-1:0]      s1_y_angle;

  logic [XW-1:0]           x_wide;
  logic [XW-1:0]           y_wide;
  logic [ANGLE_W-1:0]      x_off;
  logic [ANGLE_W-1:0]      y_off;
  logic [2*COORD_W-1:0]    spread;
  ptg_disp_req_t           req_next;

  logic                    s2_valid;

  assign accept       = ctl.in_valid && ctl.load_s1;
  assign x_angle_next = x_angle + 9'd1;
  assign y_angle_next = y_angle - 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_angle  <= '0;
      y_angle  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept && first_of_frame) begin
        x_angle <= x_angle_next;
        y_angle <= y_angle_next;
      end
      if (ctl.load_s1) begin
        s1_valid <= ctl.in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_s1) begin
      s1_first   <= first_of_frame;
      s1_tex_x   <= tex_x;
      s1_tex_y   <= tex_y;
      s1_x_angle <= first_of_frame ? x_angle_next : x_angle;
      s1_y_angle <= first_of_frame ? y_angle_next : y_angle;
    end
  end

  assign amp_x_new = {cosine_at(s1_y_angle), 1'b0};
  assign amp_y_new = {sine_at(s1_x_angle), 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      x_amplitude <= AMP_W'(AMP_RESET);
      y_amplitude <= AMP_W'(AMP_RESET);
    end else if (s1_valid && ctl.load_s2 && s1_first) begin
      x_amplitude <= amp_x_new;
      y_amplitude <= amp_y_new;
    end
  end

  assign x_wide = XW'(s1_tex_x) + XW'(TEXEL_OFFSET);
  assign y_wide = XW'(s1_tex_y) + XW'(TEXEL_OFFSET);
  assign x_off  = x_wide[ANGLE_W-1:0];
  assign y_off  = y_wide[ANGLE_W-1:0];

  for (genvar b = 0; b < COORD_W; b++) begin : g_spread
    assign spread[2*b]   = s1_tex_y[b];
    assign spread[2*b+1] = s1_tex_x[b];
  end

  always_comb begin
    req_next.amp_x   = s1_first ? amp_x_new : x_amplitude;
    req_next.amp_y   = s1_first ? amp_y_new : y_amplitude;
    req_next.idx_sin = s1_x_angle + {y_off[ANGLE_W-2:0], 1'b0} + y_off;
    req_next.idx_cos = s1_y_angle + {x_off[ANGLE_W-3:0], 2'b00};
    req_next.x_low   = x_off[LOW_W-1:0];
    req_next.y_low   = y_off[LOW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ctl.load_s2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_s2) begin
      req     <= req_next;
      address <= spread;
    end
  end

  assign sts.valid_a = s1_valid;
  assign sts.valid_b = s2_valid;

  `PTG_ASSERT_NEXT(a_x_angle_step, clk, rst, accept && first_of_frame, x_angle == $past(x_angle) + 9'd1)
  `PTG_ASSERT_NEXT(a_y_angle_hold, clk, rst, !(accept && first_of_frame), $stable(y_angle))
  `PTG_ASSERT_HOLDS(a_amp_range, clk, rst, x_amplitude >= -11'sd512 && x_amplitude <= 11'sd512)

endmodule

`default_nettype wire

FILE: hw/rtl/ptg_displace.sv
// Displacement table lookup and signed amplitude multiply stages.
`default_nettype none

module ptg_displace
  import ptg_pkg::*;
#(
  parameter int ADDR_W = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ptg_disp_ctl_t      ctl,
  input  wire logic               in_valid,
  input  wire ptg_disp_req_t      req,
  input  wire logic [ADDR_W-1:0]  address_in,
  output ptg_stage_sts_t          sts,
  output ptg_shade_req_t          shade,
  output logic [ADDR_W-1:0]       address_out
);

  logic                     s3_valid;
  logic signed [TRIG_W-1:0] s3_sin;
  logic signed [TRIG_W-1:0] s3_cos;
  logic signed [AMP_W-1:0]  s3_amp_x;
  logic signed [AMP_W-1:0]  s3_amp_y;
  logic [LOW_W-1:0]         s3_x_low;
  logic [LOW_W-1:0]         s3_y_low;
  logic [ADDR_W-1:0]        s3_address;
  logic                     s4_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (ctl.load_s3) begin
        s3_valid <= in_valid;
      end
      if (ctl.load_s4) begin
        s4_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_s3) begin
      s3_sin     <= sine_at(req.idx_sin);
      s3_cos     <= cosine_at(req.idx_cos);
      s3_amp_x   <= req.amp_x;
      s3_amp_y   <= req.amp_y;
      s3_x_low   <= req.x_low;
      s3_y_low   <= req.y_low;
      s3_address <= address_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_s4) begin
      shade.prod_x <= PROD_W'(s3_sin) * PROD_W'(s3_amp_x);
      shade.prod_y <= PROD_W'(s3_cos) * PROD_W'(s3_amp_y);
      shade.x_low  <= s3_x_low;
      shade.y_low  <= s3_y_low;
      address_out  <= s3_address;
    end
  end

  assign sts.valid_a = s3_valid;
  assign sts.valid_b = s4_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/ptg_shade.sv
// Scaling, folding and RGB565 packing into the output register.
`default_nettype none

module ptg_shade
  import ptg_pkg::*;
#(
  parameter int ADDR_W = 12
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic               in_valid,
  input  wire ptg_shade_req_t     shade,
  input  wire logic [ADDR_W-1:0]  address_in,
  output logic                    out_valid,
  output logic [ADDR_W-1:0]       texel_address,
  output logic [PIXEL_W-1:0]      pixel_value
);

  logic [PROD_W-1:0] adj_x;
  logic [PROD_W-1:0] adj_y;
  logic [LOW_W-1:0]  sum;
  logic [6:0]        level;
  logic [3:0]        red_blue;
  logic [4:0]        green;

  // Adding 255 to a negative product before the shift truncates toward zero.
  assign adj_x = PROD_W'(shade.prod_x) + (shade.prod_x[PROD_W-1] ? PROD_W'(255) : '0);
  assign adj_y = PROD_W'(shade.prod_y) + (shade.prod_y[PROD_W-1] ? PROD_W'(255) : '0);

  assign sum      = shade.x_low + adj_x[15:8] + shade.y_low + adj_y[15:8];
  assign level    = sum[7] ? ~sum[6:0] : sum[6:0];
  assign red_blue = level[6:3];
  assign green    = level[6:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      texel_address <= address_in;
      pixel_value   <= {1'b0, red_blue, 1'b0, green, 1'b0, red_blue};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/plasma_texel_generator.sv
// Top level of the plasma texel generator: pipeline control and stage wiring.
//
// The request channel (req_valid, req_stall) carries one word per texel:
// first_of_frame, tex_x and tex_y. Setting first_of_frame advances the frame
// angles and reloads the amplitudes before that texel is shaded.
// The pixel channel (pix_valid, pix_stall) returns one word per request, in
// order: the twiddled texel_address and a gray RGB565 pixel_value.
// A word is moved at a rising edge where valid is high and stall is low.
// A word passes five registers: frame stage, index stage, table lookup, multiply
// and the shading output register, which drives pix_valid.
// Throughput is one texel per cycle while pix_stall is low; every stage holds one word.
// When the receiver stalls, the output register holds its word and the
// stages behind it keep filling empty slots, so req_stall rises only once
// the whole pipeline is full. Releasing pix_stall frees every stage at once.
// Reset clears all valid bits, sets both angles to zero and both amplitudes
// to 256. The sine and cosine tables are constant logic.
`default_nettype none
`include "plasma_texel_generator_defines.svh"

module plasma_texel_generator
  import ptg_pkg::*;
#(
  parameter int TEX_SIZE = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire logic                             first_of_frame,
  input  wire logic [$clog2(TEX_SIZE)-1:0]      tex_x,
  input  wire logic [$clog2(TEX_SIZE)-1:0]      tex_y,
  output logic                                  pix_valid,
  input  wire logic                             pix_stall,
  output logic [2*$clog2(TEX_SIZE)-1:0]         texel_address,
  output logic [PIXEL_W-1:0]                    pixel_value
);

  localparam int COORD_W = $clog2(TEX_SIZE);
  localparam int ADDR_W  = 2 * COORD_W;

  ptg_frame_ctl_t    frame_ctl;
  ptg_disp_ctl_t     disp_ctl;
  ptg_stage_sts_t    frame_sts;
  ptg_stage_sts_t    disp_sts;
  ptg_disp_req_t     disp_req;
  ptg_shade_req_t    shade_req;
  logic [ADDR_W-1:0] addr_s2;
  logic [ADDR_W-1:0] addr_s4;

  logic ready_out;
  logic ready_s4;
  logic ready_s3;
  logic ready_s2;
  logic ready_s1;

  assign ready_out = !pix_valid || !pix_stall;
  assign ready_s4  = !disp_sts.valid_b || ready_out;
  assign ready_s3  = !disp_sts.valid_a || ready_s4;
  assign ready_s2  = !frame_sts.valid_b || ready_s3;
  assign ready_s1  = !frame_sts.valid_a || ready_s2;
  assign req_stall = !ready_s1;

  assign frame_ctl.in_valid = req_valid;
  assign frame_ctl.load_s1  = ready_s1;
  assign frame_ctl.load_s2  = ready_s2;
  assign disp_ctl.load_s3   = ready_s3;
  assign disp_ctl.load_s4   = ready_s4;

  ptg_frame #(
    .COORD_W (COORD_W)
  ) u_frame (
    .clk            (clk),
    .rst            (rst),
    .ctl            (frame_ctl),
    .first_of_frame (first_of_frame),
    .tex_x          (tex_x),
    .tex_y          (tex_y),
    .sts            (frame_sts),
    .req            (disp_req),
    .address        (addr_s2)
  );

  ptg_displace #(
    .ADDR_W (ADDR_W)
  ) u_displace (
    .clk         (clk),
    .rst         (rst),
    .ctl         (disp_ctl),
    .in_valid    (frame_sts.valid_b),
    .req         (disp_req),
    .address_in  (addr_s2),
    .sts         (disp_sts),
    .shade       (shade_req),
    .address_out (addr_s4)
  );

  ptg_shade #(
    .ADDR_W (ADDR_W)
  ) u_shade (
    .clk           (clk),
    .rst           (rst),
    .load          (ready_out),
    .in_valid      (disp_sts.valid_b),
    .shade         (shade_req),
    .address_in    (addr_s4),
    .out_valid     (pix_valid),
    .texel_address (texel_address),
    .pixel_value   (pixel_value)
  );

  `PTG_ASSERT_HOLDS(a_no_stall_when_drained, clk, rst, !pix_stall |-> !req_stall)

endmodule

`default_nettype wire
